[hdl/ape_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the
// averaged perceptron engine. No dependencies.
package ape_pkg;

	localparam int APE_MOVE_COUNT = 32;
	localparam int APE_ROW_COUNT  = 4096;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Operation selected by one request.
	typedef enum logic [1:0] {
		MODE_SCORE  = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_ARGMAX = 2'd2,
		MODE_AVG    = 2'd3
	} ape_mode_t;

	// Request payload.
	typedef struct packed {
		ape_mode_t          mode;
		logic               first;
		logic [11:0]        feature_index;
		logic signed [31:0] feature_value;
		logic [4:0]         guess_move;
		logic [4:0]         truth_move;
		logic [31:0]        allowed_mask;
	} ape_in_t;

	// Result payload.
	typedef struct packed {
		logic [4:0]         best_move;
		logic signed [47:0] top_score;
		logic               found;
	} ape_out_t;

	// One stored entry: weight, accumulated weight and last-update stamp.
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [63:0] acc;
		logic [31:0]        stamp;
	} ape_entry_t;

	// Controller state.
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH,
		ST_SC_RD, ST_SC_ADD, ST_AM,
		ST_UP_RD, ST_UP_LAT, ST_UP_MUL, ST_UP_ACC, ST_UP_WR,
		ST_AV_RD, ST_AV_LAT, ST_AV_MUL, ST_AV_ACC, ST_AV_DIV, ST_AV_WAIT, ST_AV_WR,
		ST_DONE
	} ape_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clr_step;
		logic rd;
		logic lat;
		logic mul;
		logic acc;
		logic div_go;
		logic wr_upd;
		logic wr_avg;
		logic sc_add;
		logic am_step;
		logic pred_sel;
	} ape_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		ape_mode_t mode;
		logic      clr_last;
		logic      row_ok;
		logic      upd_ok;
		logic      avg_ok;
		logic      skip;
		logic      div_done;
	} ape_sts_t;

	// Saturating 64-bit signed add.
	function automatic logic signed [63:0] add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			add64 = s[64] ? S64_MIN : S64_MAX;
		end else begin
			add64 = s[63:0];
		end
	endfunction

	// Saturating add of a 32-bit weight into a 48-bit score.
	function automatic logic signed [47:0] add48(input logic signed [47:0] a,
			input logic signed [31:0] b);
		logic [48:0] s;
		s = {a[47], a} + {{17{b[31]}}, b};
		if (s[48] != s[47]) begin
			add48 = s[48] ? S48_MIN : S48_MAX;
		end else begin
			add48 = s[47:0];
		end
	endfunction

	// Weight plus a 33-bit delta, saturated to 32 bits.
	function automatic logic signed [31:0] addw(input logic signed [31:0] w,
			input logic signed [32:0] d);
		logic [33:0] s;
		s = {w[31], w[31], w} + {d[32], d};
		if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
			addw = s[31:0];
		end else begin
			addw = s[33] ? S32_MIN : S32_MAX;
		end
	endfunction

endpackage

[hdl/averaged_perceptron_engine_top.sv]
// Top level of the averaged perceptron engine: controller plus datapath.
// Depends on ape_pkg, ape_ctrl and ape_dp.
//
// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot stall it. After reset the entry memory is swept to zero, one entry a
// cycle, ROW_COUNT*MOVE_COUNT entries (131072 by default), with busy high.
// Score does one memory read and one add per move; update takes two entries
// through read, latch, multiply, accumulate and write; argmax compares one
// move per cycle over min(MOVE_COUNT,32) moves; average skips each entry of
// the row never updated and runs each other through the one-bit-per-cycle
// 64-step divider. Requests with an out-of-range row or move, updates with
// equal moves and averages before any update go straight to done.
module averaged_perceptron_engine_top
	import ape_pkg::*;
#(
	parameter int MOVE_COUNT = APE_MOVE_COUNT,
	parameter int ROW_COUNT  = APE_ROW_COUNT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ape_in_t  item,
	output logic     done,
	output ape_out_t result
);

	ape_cmd_t                      cmd;
	ape_sts_t                      sts;
	logic [$clog2(MOVE_COUNT)-1:0] move_idx;

	ape_ctrl #(
		.MOVE_COUNT(MOVE_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sts      (sts),
		.cmd      (cmd),
		.move_idx (move_idx),
		.busy     (busy),
		.done     (done)
	);

	ape_dp #(
		.MOVE_COUNT(MOVE_COUNT),
		.ROW_COUNT (ROW_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cmd      (cmd),
		.move_idx (move_idx),
		.sts      (sts),
		.result   (result)
	);

endmodule

[hdl/ape_ram.sv]
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module ape_ram #(
	parameter int W = 128,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);

	logic [W-1:0] mem [D];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/ape_div.sv]
// Restoring divider, one quotient bit per cycle: signed 64-bit dividend by
// unsigned 32-bit divisor, quotient truncated and saturated to 32 bits.
// Depends on ape_pkg.
module ape_div
	import ape_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [63:0] dividend,
	input  logic [31:0]        divisor,
	output logic               done,
	output logic signed [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [63:0] num_q;
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic        fits;

	// One restoring step.
	assign trial = {rem_q, num_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand and quotient registers.
	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[63];
			num_q <= dividend[63] ? 64'(-dividend) : dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], fits};
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
		end
	end

	// Sign and saturation of the finished magnitude.
	always_comb begin
		if (neg_q) begin
			quotient = (quo_q > 64'h8000_0000) ? S32_MIN : 32'(-quo_q[31:0]);
		end else begin
			quotient = (quo_q > 64'h7FFF_FFFF) ? S32_MAX : quo_q[31:0];
		end
	end

	assign done = done_q;

endmodule

[hdl/ape_dp.sv]
// Datapath: entry memory, score sums, update counter, multiplier, divider
// and argmax registers. Depends on ape_pkg, ape_ram and ape_div.
module ape_dp
	import ape_pkg::*;
#(
	parameter int MOVE_COUNT = APE_MOVE_COUNT,
	parameter int ROW_COUNT  = APE_ROW_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ape_in_t                       item,
	input  ape_cmd_t                      cmd,
	input  logic [$clog2(MOVE_COUNT)-1:0] move_idx,
	output ape_sts_t                      sts,
	output ape_out_t                      result
);

	localparam int DEPTH = ROW_COUNT * MOVE_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = $clog2(MOVE_COUNT);

	ape_in_t            item_q;
	logic [AW-1:0]      base_q;
	logic [31:0]        total_q;
	logic signed [47:0] score_q [MOVE_COUNT];
	logic [AW-1:0]      clr_addr_q;
	logic signed [31:0] ent_w_q;
	logic signed [63:0] ent_acc_q;
	logic [31:0]        ent_stamp_q;
	logic [31:0]        missed_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic [4:0]         best_q;
	logic signed [47:0] top_val_q;
	logic               found_q;

	logic               row_ok;
	logic [4:0]         upd_move;
	logic [MW-1:0]      ent_move;
	logic [AW-1:0]      ent_addr;
	ape_entry_t         rd_ent;
	ape_entry_t         wr_ent;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [64:0] prod_full;
	logic signed [32:0] delta;
	logic               div_done;
	logic signed [31:0] div_q;
	logic signed [47:0] cur_score;
	logic               am_take;

	// Row and move checks on the held request.
	assign row_ok = 32'(item_q.feature_index) < ROW_COUNT;

	always_comb begin
		sts.mode     = item_q.mode;
		sts.clr_last = clr_addr_q == AW'(DEPTH - 1);
		sts.row_ok   = row_ok;
		sts.upd_ok   = row_ok && (item_q.guess_move != item_q.truth_move)
			&& (32'(item_q.guess_move) < MOVE_COUNT)
			&& (32'(item_q.truth_move) < MOVE_COUNT);
		sts.avg_ok   = row_ok && (total_q != '0);
		sts.skip     = ent_stamp_q == '0;
		sts.div_done = div_done;
	end

	// Entry address: gold or predicted move on update, walked move otherwise.
	assign upd_move = cmd.pred_sel ? item_q.guess_move : item_q.truth_move;
	assign ent_move = (item_q.mode == MODE_UPDATE) ? MW'(upd_move) : move_idx;
	assign ent_addr = base_q + AW'(ent_move);

	// Update delta: gold gains the feature value, predicted loses it.
	assign delta = cmd.pred_sel ? 33'(-{item_q.feature_value[31], item_q.feature_value})
		: {item_q.feature_value[31], item_q.feature_value};

	// Write data for clearing, update and average.
	always_comb begin
		wr_ent.stamp = total_q;
		if (cmd.wr_avg) begin
			wr_ent.w   = div_q;
			wr_ent.acc = acc_q;
		end else begin
			wr_ent.w   = addw(ent_w_q, delta);
			wr_ent.acc = add64(acc_q, 64'({{31{delta[32]}}, delta}));
		end
		if (cmd.clr_step) begin
			wr_ent = '0;
		end
	end

	assign wr_en   = cmd.clr_step || cmd.wr_upd || cmd.wr_avg;
	assign wr_addr = cmd.clr_step ? clr_addr_q : ent_addr;

	ape_ram #(
		.W($bits(ape_entry_t)),
		.D(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (cmd.rd),
		.rd_addr (ent_addr),
		.rd_data (rd_ent)
	);

	ape_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (acc_q),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Catch-up product of missed steps and weight.
	assign prod_full = $signed({1'b0, missed_q}) * ent_w_q;

	// Argmax step on the walked move.
	assign cur_score = score_q[move_idx];
	assign am_take   = item_q.allowed_mask[5'(move_idx)] && (!found_q || cur_score >= top_val_q);

	// State with reset: counter, score sums, clearing address, argmax result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			clr_addr_q <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			top_val_q  <= '0;
			for (int i = 0; i < MOVE_COUNT; i++) begin
				score_q[i] <= '0;
			end
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.load) begin
				found_q    <= 1'b0;
				best_q     <= '0;
				top_val_q  <= '0;
				if (item.mode == MODE_UPDATE && item.first && total_q != '1) begin
					total_q <= total_q + 32'd1;
				end
				if (item.mode == MODE_SCORE && item.first) begin
					for (int i = 0; i < MOVE_COUNT; i++) begin
						score_q[i] <= '0;
					end
				end
			end
			if (cmd.sc_add) begin
				score_q[move_idx] <= add48(score_q[move_idx], rd_ent.w);
			end
			if (cmd.am_step && am_take) begin
				found_q    <= 1'b1;
				best_q     <= 5'(move_idx);
				top_val_q  <= cur_score;
			end
		end
	end

	// Payload registers: held request and entry arithmetic.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			base_q <= AW'(32'(item.feature_index) * MOVE_COUNT);
		end
		if (cmd.lat) begin
			ent_w_q     <= rd_ent.w;
			ent_acc_q   <= rd_ent.acc;
			ent_stamp_q <= rd_ent.stamp;
			if (total_q > rd_ent.stamp) begin
				missed_q <= (item_q.mode == MODE_UPDATE) ? total_q - rd_ent.stamp - 32'd1
					: total_q - rd_ent.stamp;
			end else begin
				missed_q <= '0;
			end
		end
		if (cmd.mul) begin
			prod_q <= prod_full[63:0];
		end
		if (cmd.acc) begin
			acc_q <= add64(ent_acc_q, prod_q);
		end
	end

	assign result.best_move = best_q;
	assign result.top_score = top_val_q;
	assign result.found     = found_q;

endmodule

[hdl/ape_ctrl.sv]
// Controller state machine: sequences clearing, the per-move walks and the
// per-entry update and average steps. Depends on ape_pkg.
module ape_ctrl
	import ape_pkg::*;
#(
	parameter int MOVE_COUNT = APE_MOVE_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  ape_sts_t                      sts,
	output ape_cmd_t                      cmd,
	output logic [$clog2(MOVE_COUNT)-1:0] move_idx,
	output logic                          busy,
	output logic                          done
);

	localparam int MW = $clog2(MOVE_COUNT);
	localparam int AM = (MOVE_COUNT < 32) ? MOVE_COUNT : 32;

	ape_state_t    state_q, state_d;
	logic [MW-1:0] cnt_q, cnt_d;
	logic          pred_q, pred_d;
	logic          last_move;

	assign last_move = cnt_q == MW'(MOVE_COUNT - 1);

	// Registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			pred_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pred_q  <= pred_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pred_d  = pred_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				cnt_d  = '0;
				pred_d = 1'b0;
				unique case (sts.mode)
					MODE_SCORE:  state_d = sts.row_ok ? ST_SC_RD : ST_DONE;
					MODE_UPDATE: state_d = sts.upd_ok ? ST_UP_RD : ST_DONE;
					MODE_ARGMAX: state_d = ST_AM;
					MODE_AVG:    state_d = sts.avg_ok ? ST_AV_RD : ST_DONE;
				endcase
			end
			ST_SC_RD: state_d = ST_SC_ADD;
			ST_SC_ADD: begin
				if (last_move) begin
					state_d = ST_DONE;
				end else begin
					cnt_d   = cnt_q + MW'(1);
					state_d = ST_SC_RD;
				end
			end
			ST_AM: begin
				if (cnt_q == MW'(AM - 1)) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + MW'(1);
				end
			end
			ST_UP_RD:  state_d = ST_UP_LAT;
			ST_UP_LAT: state_d = ST_UP_MUL;
			ST_UP_MUL: state_d = ST_UP_ACC;
			ST_UP_ACC: state_d = ST_UP_WR;
			ST_UP_WR: begin
				if (pred_q) begin
					state_d = ST_DONE;
				end else begin
					pred_d  = 1'b1;
					state_d = ST_UP_RD;
				end
			end
			ST_AV_RD:  state_d = ST_AV_LAT;
			ST_AV_LAT: state_d = ST_AV_MUL;
			ST_AV_MUL: begin
				// Entries never updated keep their values.
				if (!sts.skip) begin
					state_d = ST_AV_ACC;
				end else if (last_move) begin
					state_d = ST_DONE;
				end else begin
					cnt_d   = cnt_q + MW'(1);
					state_d = ST_AV_RD;
				end
			end
			ST_AV_ACC:  state_d = ST_AV_DIV;
			ST_AV_DIV:  state_d = ST_AV_WAIT;
			ST_AV_WAIT: if (sts.div_done) state_d = ST_AV_WR;
			ST_AV_WR: begin
				if (last_move) begin
					state_d = ST_DONE;
				end else begin
					cnt_d   = cnt_q + MW'(1);
					state_d = ST_AV_RD;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd          = '0;
		cmd.pred_sel = pred_q;
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.clr_step = state_q == ST_CLEAR;
		cmd.rd       = (state_q == ST_SC_RD) || (state_q == ST_UP_RD) || (state_q == ST_AV_RD);
		cmd.lat      = (state_q == ST_UP_LAT) || (state_q == ST_AV_LAT);
		cmd.mul      = (state_q == ST_UP_MUL) || (state_q == ST_AV_MUL);
		cmd.acc      = (state_q == ST_UP_ACC) || (state_q == ST_AV_ACC);
		cmd.div_go   = state_q == ST_AV_DIV;
		cmd.wr_upd   = state_q == ST_UP_WR;
		cmd.wr_avg   = state_q == ST_AV_WR;
		cmd.sc_add   = state_q == ST_SC_ADD;
		cmd.am_step  = state_q == ST_AM;
		busy         = state_q != ST_IDLE;
		done         = state_q == ST_DONE;
	end

	assign move_idx = cnt_q;

endmodule

[hdl/ape_chk.sv]
// Port-level checks on the engine's request and result timing, bound to the
// top level. Depends on ape_pkg and averaged_perceptron_engine_top.
module ape_chk
	import ape_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input ape_in_t  item,
	input logic     done,
	input ape_out_t result
);

	// A result appears only while a request is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	// Once the result is shown the engine takes the next request.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");

	// An accepted request occupies the engine in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but not busy");

	// A result without a found move carries zero fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.best_move == '0 && result.top_score == '0))
		else $error("nonzero fields without found");

endmodule

bind averaged_perceptron_engine_top ape_chk u_chk (.*);

[sim/ape_checker.sv]
// Result checker for the averaged perceptron engine: predicts each request's
// result from its own copy of the weight state and compares. Depends on ape_pkg.
module ape_checker
	import ape_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  ape_in_t  item,
	input  logic     done,
	input  ape_out_t result,
	output int       errors,
	output int       pending
);

	localparam longint W_MAX = 64'sh7FFF_FFFF;
	localparam longint W_MIN = -64'sh8000_0000;
	localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -64'sh8000_0000_0000;

	// Sparse model of the entry memory; entries never touched read as zero.
	longint weight_m[int];
	longint acc_m[int];
	logic [31:0] stamp_m[int];
	logic [31:0] total_updates;
	longint score_m[32];
	ape_out_t expected_results[$];

	function automatic longint clamp_weight(input longint x);
		if (x > W_MAX) return W_MAX;
		if (x < W_MIN) return W_MIN;
		return x;
	endfunction

	// Saturating 64-bit add through a 65-bit sum.
	function automatic longint sat_add64(input longint a, input longint b);
		logic signed [64:0] s;
		s = 65'(signed'(a)) + 65'(signed'(b));
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return longint'(s);
	endfunction

	function automatic longint get_w(input int e);
		return weight_m.exists(e) ? weight_m[e] : 0;
	endfunction

	function automatic longint get_acc(input int e);
		return acc_m.exists(e) ? acc_m[e] : 0;
	endfunction

	function automatic logic [31:0] get_stamp(input int e);
		return stamp_m.exists(e) ? stamp_m[e] : 32'd0;
	endfunction

	// Bring an entry's accumulator up to the current update count.
	task automatic catch_up(input int e, input logic [31:0] t);
		logic [31:0] s;
		logic [31:0] missed;
		s = get_stamp(e);
		missed = (t > s) ? t - s - 32'd1 : 32'd0;
		acc_m[e] = sat_add64(get_acc(e), longint'({32'd0, missed}) * get_w(e));
		stamp_m[e] = t;
	endtask

	task automatic apply_delta(input int e, input longint d);
		weight_m[e] = clamp_weight(get_w(e) + d);
		acc_m[e] = sat_add64(get_acc(e), d);
	endtask

	// Compute the result of one request and update the model state.
	task automatic predict_request(input ape_in_t q, output ape_out_t r);
		int base;
		int e;
		longint v;
		longint s;
		longint top_val;
		logic [31:0] missed;
		logic [31:0] st;
		bit got;
		r = '0;
		base = int'(q.feature_index) * APE_MOVE_COUNT;
		v = longint'(q.feature_value);
		case (q.mode)
			MODE_SCORE: begin
				if (q.first) begin
					for (int m = 0; m < 32; m++) score_m[m] = 0;
				end
				if (q.feature_index < APE_ROW_COUNT) begin
					for (int m = 0; m < APE_MOVE_COUNT; m++) begin
						s = score_m[m] + get_w(base + m);
						if (s > SUM_MAX) s = SUM_MAX;
						if (s < SUM_MIN) s = SUM_MIN;
						score_m[m] = s;
					end
				end
			end
			MODE_UPDATE: begin
				if (q.first && total_updates != 32'hFFFF_FFFF) total_updates++;
				if (q.feature_index < APE_ROW_COUNT && q.guess_move != q.truth_move) begin
					catch_up(base + q.guess_move, total_updates);
					catch_up(base + q.truth_move, total_updates);
					apply_delta(base + q.truth_move, v);
					apply_delta(base + q.guess_move, -v);
				end
			end
			MODE_ARGMAX: begin
				got = 0;
				top_val = 0;
				for (int m = 0; m < 32; m++) begin
					if (q.allowed_mask[m] && (!got || score_m[m] >= top_val)) begin
						got = 1;
						r.best_move = 5'(m);
						top_val = score_m[m];
					end
				end
				if (got) begin
					r.top_score = 48'(top_val);
					r.found = 1'b1;
				end
			end
			default: begin
				// Averaging folds the pending weight history in, then divides.
				if (q.feature_index < APE_ROW_COUNT && total_updates != 0) begin
					for (int m = 0; m < APE_MOVE_COUNT; m++) begin
						e = base + m;
						st = get_stamp(e);
						if (st != 0) begin
							missed = (total_updates > st) ? total_updates - st : 32'd0;
							acc_m[e] = sat_add64(get_acc(e),
								longint'({32'd0, missed}) * get_w(e));
							stamp_m[e] = total_updates;
							weight_m[e] = clamp_weight(acc_m[e] /
								longint'({32'd0, total_updates}));
						end
					end
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("ape_checker: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	initial begin
		errors = 0;
		total_updates = 0;
		for (int m = 0; m < 32; m++) score_m[m] = 0;
	end

	// Results are compared before a request taken at the same edge is queued.
	always @(posedge clk) begin
		ape_out_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					exp_r = expected_results.pop_front();
					if (result.best_move !== exp_r.best_move)
						report_mismatch($sformatf("best_move %0d, expected %0d",
							result.best_move, exp_r.best_move));
					if (result.top_score !== exp_r.top_score)
						report_mismatch($sformatf("top_score %0d, expected %0d",
							result.top_score, exp_r.top_score));
					if (result.found !== exp_r.found)
						report_mismatch($sformatf("found %0b, expected %0b",
							result.found, exp_r.found));
				end
			end
			if (start && !busy) begin
				predict_request(item, exp_r);
				expected_results.push_back(exp_r);
			end
		end
		pending = expected_results.size();
	end

endmodule

[sim/tb_averaged_perceptron_engine_top.sv]
// Testbench top for the averaged perceptron engine: clock, reset, directed and
// random requests, verdict. Depends on ape_pkg, ape_checker and the engine RTL.
module tb_averaged_perceptron_engine_top;
	import ape_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ape_in_t  item;
	logic     done;
	ape_out_t result;
	int       errors;
	int       pending;
	int       burst_left;
	int       sent;

	averaged_perceptron_engine_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	ape_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Present one request and hold it until the engine takes it, then idle
	// between bursts for a random number of cycles.
	task automatic send_request(input ape_in_t q);
		start <= 1'b1;
		item <= q;
		do @(posedge clk); while (busy);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(0, 12);
		end
	endtask

	// Mode and first flag from the arguments, random values in the other fields.
	function automatic ape_in_t rand_request(input ape_mode_t md, input logic fst);
		ape_in_t q;
		int sel;
		q.mode = md;
		q.first = fst;
		q.feature_index = ($urandom_range(9) < 8) ? 12'($urandom_range(15)) : 12'($urandom);
		sel = $urandom_range(19);
		if (sel == 0) q.feature_value = S32_MAX;
		else if (sel == 1) q.feature_value = S32_MIN;
		else if (sel < 5) q.feature_value = $urandom;
		else q.feature_value = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
		q.guess_move = 5'($urandom);
		q.truth_move = ($urandom_range(9) == 0) ? q.guess_move : 5'($urandom);
		sel = $urandom_range(9);
		if (sel == 0) q.allowed_mask = '0;
		else if (sel == 1) q.allowed_mask = '1;
		else if (sel == 2) q.allowed_mask = 32'd1 << $urandom_range(31);
		else q.allowed_mask = $urandom;
		return q;
	endfunction

	function automatic ape_in_t make_request(input ape_mode_t md, input logic fst,
			input logic [11:0] row, input logic signed [31:0] val,
			input logic [4:0] pm, input logic [4:0] gm, input logic [31:0] mask);
		ape_in_t q;
		q.mode = md;
		q.first = fst;
		q.feature_index = row;
		q.feature_value = val;
		q.guess_move = pm;
		q.truth_move = gm;
		q.allowed_mask = mask;
		return q;
	endfunction

	initial begin
		int kind;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		burst_left = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty state, averaging before any update, counter untouched.
		send_request(make_request(MODE_ARGMAX, 1'b0, 12'd0, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_ARGMAX, 1'b0, 12'd0, 32'sd0, 5'd0, 5'd0, '1));
		send_request(make_request(MODE_AVG, 1'b0, 12'd3, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_UPDATE, 1'b0, 12'd1, 32'sd65536, 5'd2, 5'd7, 32'h0));
		// Same-move update, extremes of value and moves, highest row.
		send_request(make_request(MODE_UPDATE, 1'b1, 12'd1, 32'sd65536, 5'd4, 5'd4, 32'h0));
		send_request(make_request(MODE_UPDATE, 1'b1, 12'd1, S32_MAX, 5'd0, 5'd31, 32'h0));
		send_request(make_request(MODE_UPDATE, 1'b0, 12'd1, S32_MAX, 5'd0, 5'd31, 32'h0));
		send_request(make_request(MODE_UPDATE, 1'b1, 12'd1, S32_MIN, 5'd31, 5'd0, 32'h0));
		send_request(make_request(MODE_UPDATE, 1'b1, 12'd4095, S32_MIN, 5'd5, 5'd9, 32'h0));
		send_request(make_request(MODE_UPDATE, 1'b0, 12'd4095, 32'sd1, 5'd9, 5'd5, 32'h0));
		// Score sums across rows, then argmax including ties.
		send_request(make_request(MODE_SCORE, 1'b1, 12'd1, 32'sd0, 5'd0, 5'd0, 32'h0));
		repeat (4)
			send_request(make_request(MODE_SCORE, 1'b0, 12'd1, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_SCORE, 1'b0, 12'd4095, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_ARGMAX, 1'b0, 12'd0, 32'sd0, 5'd0, 5'd0, '1));
		send_request(make_request(MODE_ARGMAX, 1'b0, 12'd0, 32'sd0, 5'd0, 5'd0, 32'h0000_0006));
		send_request(make_request(MODE_ARGMAX, 1'b0, 12'd0, 32'sd0, 5'd0, 5'd0, 32'h8000_0001));
		// Averaging twice on a row must leave it unchanged the second time.
		send_request(make_request(MODE_AVG, 1'b0, 12'd1, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_AVG, 1'b1, 12'd1, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_AVG, 1'b0, 12'd4095, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_SCORE, 1'b1, 12'd1, 32'sd0, 5'd0, 5'd0, 32'h0));
		send_request(make_request(MODE_ARGMAX, 1'b0, 12'd0, 32'sd0, 5'd0, 5'd0, '1));

		// Random: mostly well-formed score passes and update groups.
		while (sent < 1220) begin
			kind = $urandom_range(99);
			if (kind < 38) begin
				send_request(rand_request(MODE_SCORE, $urandom_range(9) != 0));
				repeat ($urandom_range(1, 4)) send_request(rand_request(MODE_SCORE, 1'b0));
			end else if (kind < 72) begin
				send_request(rand_request(MODE_UPDATE, $urandom_range(9) != 0));
				repeat ($urandom_range(0, 4)) send_request(rand_request(MODE_UPDATE, 1'b0));
			end else if (kind < 95) begin
				send_request(rand_request(MODE_ARGMAX, 1'($urandom)));
			end else begin
				send_request(rand_request(MODE_AVG, 1'($urandom)));
			end
			// Drain everything midway, while the sent count is from 600 to 609, before carrying on.
			if (sent >= 600 && sent < 610) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				@(posedge clk);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("tb_averaged_perceptron_engine_top: PASS");
		end else begin
			$display("tb_averaged_perceptron_engine_top: FAIL");
		end
		$finish;
	end

	// Overall time limit covering the reset sweep and the slowest averages.
	initial begin
		#400000000;
		$display("tb_averaged_perceptron_engine_top: FAIL");
		$finish;
	end

endmodule
